// ===== sv/u8sd_pkg.sv =====
// Package: item types and status codes for the UTF-8 stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

    localparam int CP_W  = 21;
    localparam int LEN_W = 3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_BAD_CONT = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [1:0]       status;
        logic [LEN_W-1:0] seq_length;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/utf8_stream_decoder_core.sv =====
// Top level: UTF-8 byte stream decoder, one byte per item.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-------------------------------------
//   s_      | in        | s_valid / s_ready | data_byte, buffer_end
//   m_      | out       | m_valid / m_ready | code_point, status, seq_length
//
// One byte is taken every cycle while s_ready is high; a taken byte waits in the input
// register, then the decode logic updates the state and, when a result is due, loads the result register.
// The decode state (partial value, bytes due, length) updates once per decoded byte.
// Reset clears the state to idle and empties both registers.
// A stalled result holds the input register; s_ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire u8sd_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output u8sd_pkg::out_item_t       m_item
);
    import u8sd_pkg::*;

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;

    logic [CP_W-1:0]  partial_reg,  partial_next;
    logic [1:0]       due_reg,      due_next;
    logic [LEN_W-1:0] len_reg,      len_next;

    logic             out_free;
    logic             advance;
    logic             emit;
    out_item_t        result;
    logic [7:0]       b;
    logic [LEN_W-1:0] len_inc;
    logic [1:0]       due_dec;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_item   = out_item_reg;

    assign b       = in_item_reg.data_byte;
    assign len_inc = len_reg + LEN_W'(1);
    assign due_dec = due_reg - 2'd1;

    always_comb begin
        partial_next      = partial_reg;
        due_next          = due_reg;
        len_next          = len_reg;
        emit              = 1'b0;
        result.code_point = '0;
        result.status     = ST_OK;
        result.seq_length = LEN_W'(1);
        if (due_reg == 2'd0) begin
            if (b inside {[8'h00:8'h7F]}) begin
                emit              = 1'b1;
                result.code_point = CP_W'(b);
            end else if (b inside {[8'hC0:8'hF7]}) begin
                if (in_item_reg.buffer_end) begin
                    emit          = 1'b1;
                    result.status = ST_TRUNC;
                end else begin
                    len_next = LEN_W'(1);
                    if (b inside {[8'hC0:8'hDF]}) begin
                        due_next     = 2'd1;
                        partial_next = CP_W'(b & 8'h1F);
                    end else if (b inside {[8'hE0:8'hEF]}) begin
                        due_next     = 2'd2;
                        partial_next = CP_W'(b & 8'h0F);
                    end else begin
                        due_next     = 2'd3;
                        partial_next = CP_W'(b & 8'h07);
                    end
                end
            end else begin
                emit          = 1'b1;
                result.status = ST_BAD_LEAD;
            end
        end else if (!(b inside {[8'h80:8'hBF]})) begin
            emit              = 1'b1;
            result.status     = ST_BAD_CONT;
            result.seq_length = len_inc;
            partial_next      = '0;
            due_next          = 2'd0;
            len_next          = '0;
        end else begin
            partial_next = {partial_reg[CP_W-7:0], b[5:0]};
            due_next     = due_dec;
            len_next     = len_inc;
            if (due_dec == 2'd0) begin
                emit              = 1'b1;
                result.code_point = {partial_reg[CP_W-7:0], b[5:0]};
                result.seq_length = len_inc;
            end else if (in_item_reg.buffer_end) begin
                emit              = 1'b1;
                result.status     = ST_TRUNC;
                result.seq_length = len_inc;
            end
            if (emit) begin
                partial_next = '0;
                due_next     = 2'd0;
                len_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            partial_reg   <= '0;
            due_reg       <= 2'd0;
            len_reg       <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                partial_reg <= partial_next;
                due_reg     <= due_next;
                len_reg     <= len_next;
            end
            if (out_free) begin
                out_valid_reg <= advance && emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (advance && emit) begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== sv/u8sd_checker.sv =====
// Checker: port-level assertions for the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module u8sd_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire u8sd_pkg::out_item_t m_item
);
    import u8sd_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != ST_OK |-> m_item.code_point == '0)
        else $error("error result carries a code point");

    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.seq_length != 3'd0 && m_item.seq_length <= 3'd4)
        else $error("sequence length out of range");

    a_lead_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == ST_BAD_LEAD |-> m_item.seq_length == 3'd1)
        else $error("bad lead byte with length other than one");

    a_ascii: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status == ST_OK && m_item.seq_length == 3'd1
            |-> m_item.code_point < 21'd128)
        else $error("single-byte code point above ASCII");

endmodule

bind utf8_stream_decoder_core u8sd_checker u_u8sd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
